@@ hdl/ppdac_pkg.sv @@
// Shared types and constants for the ping-pong audio DAC player.
// Holds the transfer payload structs, command codes and store geometry.
// No dependencies.
package ppdac_pkg;

   localparam int BANK_DEPTH  = 1024;
   localparam int POS_W       = $clog2(BANK_DEPTH);
   localparam int ADDR_W      = POS_W + 1;
   localparam int STORE_DEPTH = 2 ** ADDR_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
   localparam logic [3:0]  CONTROL_RESET  = 4'd3;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_PLAY  = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_DEBOUNCE = 1'b0,
      CSR_CONTROL  = 1'b1
   } csr_index_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  sample_byte;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        write_accepted;
      logic        dac_valid;
      logic [15:0] dac_frame;
      logic        is_playing;
      logic        is_stopped;
   } rsp_type;

   typedef struct packed {
      logic              mem_write;
      logic              mem_read;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        sample;
      logic [3:0]        control;
      logic              write_accepted;
      logic              is_playing;
      logic              is_stopped;
   } op_type;

endpackage

@@ hdl/ppdac_front.sv @@
// Front end: accepts transfers, keeps bank pointers, play and stop flags and
// the configuration registers, and issues store operations to the back end.
// Depends on ppdac_pkg.
module ppdac_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  ppdac_pkg::req_type req_data,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic               op_full,
   output logic               op_push,
   output ppdac_pkg::op_type  op_data
);
   import ppdac_pkg::*;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BANK_DEPTH - 1);

   logic [POS_W-1:0] wpos_ff, wpos_in, rpos_ff, rpos_in;
   logic             wbank_ff, wbank_in, rbank_ff, rbank_in;
   logic             ready_ff, ready_in, play_ff, play_in, stop_ff, stop_in;
   logic [31:0]      last_ff, last_in;
   logic [15:0]      debounce_ff, debounce_in;
   logic [3:0]       control_ff, control_in;
   logic             accept, blocked, counts;
   logic [31:0]      elapsed;

   assign accept  = req_push && !op_full;
   assign elapsed = req_data.now_ms - last_ff;
   assign counts  = elapsed > {16'd0, debounce_ff};
   assign blocked = ready_ff && (wbank_ff == rbank_ff) && (wpos_ff == '0);

   always_comb begin
      wpos_in  = wpos_ff;
      wbank_in = wbank_ff;
      rpos_in  = rpos_ff;
      rbank_in = rbank_ff;
      ready_in = ready_ff;
      play_in  = play_ff;
      stop_in  = stop_ff;
      last_in  = last_ff;
      op_data  = '0;
      if (accept) begin
         case (req_data.command)
            CMD_WRITE: begin
               if (!blocked) begin
                  op_data.mem_write      = 1'b1;
                  op_data.addr           = {wbank_ff, wpos_ff};
                  op_data.write_accepted = 1'b1;
                  if (wpos_ff == POS_LAST) begin
                     wpos_in  = '0;
                     wbank_in = ~wbank_ff;
                     ready_in = 1'b1;
                  end else begin
                     wpos_in = wpos_ff + POS_W'(1);
                  end
               end
            end
            CMD_TICK: begin
               if (ready_ff && play_ff && !stop_ff) begin
                  op_data.mem_read = 1'b1;
                  op_data.addr     = {rbank_ff, rpos_ff};
                  if (rpos_ff == POS_LAST) begin
                     rpos_in  = '0;
                     rbank_in = ~rbank_ff;
                  end else begin
                     rpos_in = rpos_ff + POS_W'(1);
                  end
               end
            end
            CMD_PLAY: begin
               last_in = req_data.now_ms;
               if (counts) begin
                  play_in = ~play_ff;
               end
            end
            CMD_STOP: begin
               last_in = req_data.now_ms;
               if (counts) begin
                  stop_in = 1'b1;
               end
            end
            default: begin
               last_in = last_ff;
            end
         endcase
      end
      op_data.sample     = req_data.sample_byte;
      op_data.control    = control_ff;
      op_data.is_playing = play_in;
      op_data.is_stopped = stop_in;
   end

   assign op_push = accept;

   always_comb begin
      debounce_in = debounce_ff;
      control_in  = control_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE: debounce_in = csr_write_data;
            CSR_CONTROL:  control_in  = csr_write_data[3:0];
            default:      debounce_in = debounce_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff     <= '0;
         wbank_ff    <= 1'b0;
         rpos_ff     <= '0;
         rbank_ff    <= 1'b0;
         ready_ff    <= 1'b0;
         play_ff     <= 1'b1;
         stop_ff     <= 1'b0;
         last_ff     <= '0;
         debounce_ff <= DEBOUNCE_RESET;
         control_ff  <= CONTROL_RESET;
      end else begin
         wpos_ff     <= wpos_in;
         wbank_ff    <= wbank_in;
         rpos_ff     <= rpos_in;
         rbank_ff    <= rbank_in;
         ready_ff    <= ready_in;
         play_ff     <= play_in;
         stop_ff     <= stop_in;
         last_ff     <= last_in;
         debounce_ff <= debounce_in;
         control_ff  <= control_in;
      end
   end

endmodule

@@ hdl/ppdac_opq.sv @@
// Short operation queue between the front end and the back end.
// Depends on ppdac_pkg.
module ppdac_opq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ppdac_pkg::op_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output ppdac_pkg::op_type head
);
   import ppdac_pkg::*;

   op_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/ppdac_back.sv @@
// Back end: performs sample store writes and reads, formats DAC frames and
// holds finished results in a small output queue.
// Depends on ppdac_pkg.
module ppdac_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_empty,
   input  ppdac_pkg::op_type  op_head,
   output logic               op_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ppdac_pkg::rsp_type rsp_data
);
   import ppdac_pkg::*;

   logic [7:0]        store [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   op_type            s1_op_ff;
   logic              s1_valid_ff, s1_valid_in;
   rsp_type           s1_rsp;

   rsp_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W:0]   occupancy;
   logic              issue, do_pop;

   assign occupancy   = {1'b0, count_ff} + (QCNT_W + 1)'(s1_valid_ff);
   assign issue       = !op_empty && (occupancy < (QCNT_W + 1)'(QUEUE_DEPTH));
   assign op_pop      = issue;
   assign s1_valid_in = issue;

   always_ff @(posedge clock) begin
      if (issue) begin
         if (op_head.mem_write) begin
            store[op_head.addr] <= op_head.sample;
         end
         rd_data_ff <= store[op_head.addr];
         s1_op_ff   <= op_head;
      end
   end

   always_comb begin
      s1_rsp.write_accepted = s1_op_ff.write_accepted;
      s1_rsp.dac_valid      = s1_op_ff.mem_read;
      s1_rsp.dac_frame      = s1_op_ff.mem_read ?
                              {s1_op_ff.control, 2'b00, rd_data_ff, 2'b00} : 16'd0;
      s1_rsp.is_playing     = s1_op_ff.is_playing;
      s1_rsp.is_stopped     = s1_op_ff.is_stopped;
   end

   assign rsp_empty = count_ff == '0;
   assign do_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = s1_valid_ff ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff + QCNT_W'(s1_valid_ff) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         entry_ff[wptr_ff] <= s1_rsp;
      end
   end

endmodule

@@ hdl/pingpong_audio_dac_player_unit.sv @@
// Top level of the ping-pong audio DAC player: front end, operation queue, back end.
// Depends on ppdac_pkg, ppdac_front, ppdac_opq and ppdac_back.
// A result passes through the operation queue, the back end's store access register and its output queue.
// Throughput: one transfer per cycle while req_full is low, set by the single-port sample store access.
// Reset clears pointers, flags, queues and registers; the sample store is not cleared.
module pingpong_audio_dac_player_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  ppdac_pkg::req_type req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ppdac_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data
);
   import ppdac_pkg::*;

   logic   op_push, op_full, op_empty, op_pop;
   op_type op_in, op_head;

   assign req_full = op_full;

   ppdac_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .op_full          (op_full),
      .op_push          (op_push),
      .op_data          (op_in)
   );

   ppdac_opq u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in),
      .full      (op_full),
      .pop       (op_pop),
      .empty     (op_empty),
      .head      (op_head)
   );

   ppdac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_empty  (op_empty),
      .op_head   (op_head),
      .op_pop    (op_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
